### src/eqflm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eqflm_pkg;

   localparam int RING_DEPTH_DEF = 64;
   localparam int EVENT_BITS_DEF = 16;
   localparam int HANDLE_BITS    = 16;
   localparam int COUNT_BITS     = 7;
   localparam int OP_BITS        = 2;
   localparam int STATUS_BITS    = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_POST_FIFO = 2'd0,
      OP_POST_LIFO = 2'd1,
      OP_GET       = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE     = 2'd0,
      ST_MARGIN   = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [HANDLE_BITS-1:0] event_out;
      logic [COUNT_BITS-1:0]  free_now;
      logic [COUNT_BITS-1:0]  min_free_now;
   } rsp_type;

endpackage

`default_nettype wire

### src/eqflm_ring_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module eqflm_ring_ram #(
   parameter int DEPTH = eqflm_pkg::RING_DEPTH_DEF,
   parameter int WIDTH = eqflm_pkg::EVENT_BITS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] ram_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/eqflm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module eqflm_queue #(
   parameter int RING_DEPTH = eqflm_pkg::RING_DEPTH_DEF,
   parameter int EVENT_BITS = eqflm_pkg::EVENT_BITS_DEF,
   parameter int EW = (EVENT_BITS < eqflm_pkg::HANDLE_BITS) ? EVENT_BITS
                                                            : eqflm_pkg::HANDLE_BITS,
   parameter int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 cfg_we,
   input  wire logic [eqflm_pkg::COUNT_BITS-1:0]     cfg_len,
   input  wire logic                                 fire,
   input  wire logic [eqflm_pkg::OP_BITS-1:0]        op,
   input  wire logic [eqflm_pkg::HANDLE_BITS-1:0]    handle,
   input  wire logic                                 use_margin,
   input  wire logic [eqflm_pkg::COUNT_BITS-1:0]     margin,
   output eqflm_pkg::rsp_type                        rsp,
   output logic                                      ram_wr_en,
   output logic      [IW-1:0]                        ram_wr_addr,
   output logic      [EW-1:0]                        ram_wr_data,
   output logic                                      ram_rd_en,
   output logic      [IW-1:0]                        ram_rd_addr,
   input  wire logic [EW-1:0]                        ram_rd_data
);

   localparam int LW = $clog2(RING_DEPTH + 2);
   localparam int CW = (LW > eqflm_pkg::COUNT_BITS) ? LW : eqflm_pkg::COUNT_BITS;

   logic [LW-1:0] len_ff,   len_in;
   logic          fv_ff,    fv_in;
   logic [EW-1:0] front_ff, front_in;
   logic          pend_ff,  pend_in;
   logic [IW-1:0] head_ff,  head_in;
   logic [IW-1:0] tail_ff,  tail_in;
   logic [LW-1:0] free_ff,  free_in;
   logic [LW-1:0] min_ff,   min_in;

   logic [EW-1:0] front_cur;
   logic [EW-1:0] ev;
   logic [LW-1:0] len_m1;
   logic [IW-1:0] head_dn;
   logic [IW-1:0] tail_dn;
   logic [LW-1:0] tail_up_w;
   logic [IW-1:0] tail_up;
   logic [LW-1:0] free_dec;
   logic [LW-1:0] free_inc;
   logic [LW-1:0] min_dec;
   logic [LW-1:0] cfg_sat;
   logic          fifo_ok;

   // front slot refilled from the ring last beat: take it straight from the read port
   assign front_cur = pend_ff ? ram_rd_data : front_ff;
   assign ev        = handle[EW-1:0];

   assign len_m1    = len_ff - LW'(1);
   assign head_dn   = (head_ff == '0) ? IW'(len_m1) : head_ff - IW'(1);
   assign tail_dn   = (tail_ff == '0) ? IW'(len_m1) : tail_ff - IW'(1);
   assign tail_up_w = LW'(tail_ff) + LW'(1);
   assign tail_up   = (tail_up_w >= len_ff) ? '0 : IW'(tail_up_w);
   assign free_dec  = free_ff - LW'(1);
   assign free_inc  = free_ff + LW'(1);
   assign min_dec   = (min_ff > free_dec) ? free_dec : min_ff;
   assign cfg_sat   = (CW'(cfg_len) > CW'(RING_DEPTH)) ? LW'(RING_DEPTH) : LW'(cfg_len);
   assign fifo_ok   = use_margin ? (CW'(free_ff) > CW'(margin)) : (free_ff != '0);

   always_comb begin
      len_in      = len_ff;
      fv_in       = fv_ff;
      front_in    = front_ff;
      pend_in     = pend_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_in     = free_ff;
      min_in      = min_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = head_ff;
      ram_wr_data = ev;
      ram_rd_en   = 1'b0;
      ram_rd_addr = tail_ff;
      rsp.status    = eqflm_pkg::ST_DONE;
      rsp.event_out = '0;

      if (cfg_we) begin
         len_in   = cfg_sat;
         fv_in    = 1'b0;
         front_in = '0;
         pend_in  = 1'b0;
         head_in  = '0;
         tail_in  = '0;
         free_in  = cfg_sat + LW'(1);
         min_in   = cfg_sat + LW'(1);
      end else if (fire) begin
         front_in = front_cur;
         pend_in  = 1'b0;
         unique case (eqflm_pkg::op_type'(op))
            eqflm_pkg::OP_POST_FIFO: begin
               if (!fifo_ok) begin
                  rsp.status = use_margin ? eqflm_pkg::ST_MARGIN : eqflm_pkg::ST_OVERFLOW;
               end else begin
                  free_in = free_dec;
                  min_in  = min_dec;
                  if (!fv_ff) begin
                     front_in = ev;
                     fv_in    = 1'b1;
                  end else if (len_ff != '0) begin
                     ram_wr_en = 1'b1;
                     head_in   = head_dn;
                  end
               end
            end
            eqflm_pkg::OP_POST_LIFO: begin
               if (free_ff == '0) begin
                  rsp.status = eqflm_pkg::ST_OVERFLOW;
               end else begin
                  free_in = free_dec;
                  min_in  = min_dec;
                  if (fv_ff && len_ff != '0) begin
                     // push the old front into the ring above the tail
                     tail_in     = tail_up;
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = tail_up;
                     ram_wr_data = front_cur;
                  end
                  front_in = ev;
                  fv_in    = 1'b1;
               end
            end
            eqflm_pkg::OP_GET: begin
               if (!fv_ff) begin
                  rsp.status = eqflm_pkg::ST_EMPTY;
               end else begin
                  rsp.event_out = eqflm_pkg::HANDLE_BITS'(front_cur);
                  free_in       = free_inc;
                  if (free_inc <= len_ff) begin
                     ram_rd_en = 1'b1;
                     pend_in   = 1'b1;
                     tail_in   = tail_dn;
                  end else begin
                     fv_in    = 1'b0;
                     front_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      rsp.free_now     = eqflm_pkg::COUNT_BITS'(free_in);
      rsp.min_free_now = eqflm_pkg::COUNT_BITS'(min_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LW'(RING_DEPTH);
         fv_ff    <= 1'b0;
         front_ff <= '0;
         pend_ff  <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
         free_ff  <= LW'(RING_DEPTH + 1);
         min_ff   <= LW'(RING_DEPTH + 1);
      end else begin
         len_ff   <= len_in;
         fv_ff    <= fv_in;
         front_ff <= front_in;
         pend_ff  <= pend_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         min_ff   <= min_in;
      end
   end

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, free_ff} <= {1'b0, len_ff} + (LW+1)'(1)))
      else $error("free count above capacity");

   a_min_le_free: assert property (@(posedge clock) disable iff (reset)
      (min_ff <= free_ff))
      else $error("low-water mark above free count");

   a_pend_front: assert property (@(posedge clock) disable iff (reset)
      (pend_ff |-> fv_ff))
      else $error("ring refill pending with empty front slot");

   a_full_no_front_empty: assert property (@(posedge clock) disable iff (reset)
      (!fv_ff |-> (free_ff == len_ff + LW'(1))))
      else $error("front slot empty while queue holds items");

endmodule

`default_nettype wire

### src/event_queue_fifo_lifo_with_margin_core.sv
`timescale 1ns / 1ps
// Latency: a result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle while the response sink does not stall; a get that refills the front slot
//   reads the ring RAM in that cycle and the data is forwarded to the next beat.
// Reset (synchronous, active high): queue empty, ring length RING_DEPTH,
//   free count and low-water mark RING_DEPTH + 1; ring RAM contents are kept.
`default_nettype none

module event_queue_fifo_lifo_with_margin_core #(
   parameter int RING_DEPTH = eqflm_pkg::RING_DEPTH_DEF,
   parameter int EVENT_BITS = eqflm_pkg::EVENT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [eqflm_pkg::OP_BITS-1:0]      req_operation,
   input  wire logic [eqflm_pkg::HANDLE_BITS-1:0]  req_event_handle,
   input  wire logic                               req_use_margin,
   input  wire logic [eqflm_pkg::COUNT_BITS-1:0]   req_margin,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [eqflm_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic      [eqflm_pkg::HANDLE_BITS-1:0]  rsp_event_out,
   output logic      [eqflm_pkg::COUNT_BITS-1:0]   rsp_free_now,
   output logic      [eqflm_pkg::COUNT_BITS-1:0]   rsp_min_free_now,
   // ring length register
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [eqflm_pkg::COUNT_BITS-1:0]   csr_ring_length
);

   localparam int EW = (EVENT_BITS < eqflm_pkg::HANDLE_BITS) ? EVENT_BITS
                                                             : eqflm_pkg::HANDLE_BITS;
   localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   logic               fire;
   logic               cfg_we;
   eqflm_pkg::rsp_type rsp_next;
   eqflm_pkg::rsp_type rsp_ff;
   logic               rsp_valid_ff;
   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   logic [EW-1:0]      ram_wr_data;
   logic               ram_rd_en;
   logic [IW-1:0]      ram_rd_addr;
   logic [EW-1:0]      ram_rd_data;

   // Register writes must arrive only while idle (the user's duty; not enforced here); always take them.
   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid & csr_ready;

   // Hold off requests only while a result beat sits unclaimed and the sink stalls.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign fire      = req_valid & ~req_stall;

   eqflm_queue #(
      .RING_DEPTH (RING_DEPTH),
      .EVENT_BITS (EVENT_BITS),
      .EW         (EW),
      .IW         (IW)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .cfg_we      (cfg_we),
      .cfg_len     (csr_ring_length),
      .fire        (fire),
      .op          (req_operation),
      .handle      (req_event_handle),
      .use_margin  (req_use_margin),
      .margin      (req_margin),
      .rsp         (rsp_next),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   eqflm_ring_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (EW),
      .AW    (IW)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: load on each accepted request, drop once the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_event_out    = rsp_ff.event_out;
   assign rsp_free_now     = rsp_ff.free_now;
   assign rsp_min_free_now = rsp_ff.min_free_now;

endmodule

`default_nettype wire

### tb/sv/event_queue_fifo_lifo_with_margin_core_test.sv
`timescale 1ns / 1ps

module event_queue_fifo_lifo_with_margin_core_test;

   // The opcode that no operation uses; the block must answer it with the counts alone.
   localparam logic [eqflm_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int RING_IW = $clog2(eqflm_pkg::RING_DEPTH_DEF);

   logic                                  clock;
   logic                                  reset;

   logic                                  req_valid;
   logic                                  req_stall;
   logic [eqflm_pkg::OP_BITS-1:0]         req_operation;
   logic [eqflm_pkg::HANDLE_BITS-1:0]     req_event_handle;
   logic                                  req_use_margin;
   logic [eqflm_pkg::COUNT_BITS-1:0]      req_margin;

   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [eqflm_pkg::STATUS_BITS-1:0]     rsp_status;
   logic [eqflm_pkg::HANDLE_BITS-1:0]     rsp_event_out;
   logic [eqflm_pkg::COUNT_BITS-1:0]      rsp_free_now;
   logic [eqflm_pkg::COUNT_BITS-1:0]      rsp_min_free_now;

   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [eqflm_pkg::COUNT_BITS-1:0]      csr_ring_length;

   event_queue_fifo_lifo_with_margin_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_event_handle (req_event_handle),
      .req_use_margin   (req_use_margin),
      .req_margin       (req_margin),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_event_out    (rsp_event_out),
      .rsp_free_now     (rsp_free_now),
      .rsp_min_free_now (rsp_min_free_now),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_ring_length  (csr_ring_length)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the queue. It advances on every accepted request beat
   // and on every register write, exactly as the block should.
   // ------------------------------------------------------------------
   logic [eqflm_pkg::COUNT_BITS-1:0]  q_len;          // ring length
   logic                              q_front_full;
   logic [eqflm_pkg::HANDLE_BITS-1:0] q_front;
   logic [eqflm_pkg::HANDLE_BITS-1:0] q_ring [0:eqflm_pkg::RING_DEPTH_DEF-1];
   logic [eqflm_pkg::COUNT_BITS-1:0]  q_head;         // next slot for a FIFO post
   logic [eqflm_pkg::COUNT_BITS-1:0]  q_tail;         // next ring entry to refill the front
   logic [eqflm_pkg::COUNT_BITS-1:0]  q_free;
   logic [eqflm_pkg::COUNT_BITS-1:0]  q_low_water;

   eqflm_pkg::rsp_type due_responses [$];   // predicted response beats, oldest first
   int                 mismatches = 0;

   bit req_idling = 1'b0;        // let the sender leave gaps
   bit rsp_idling = 1'b0;        // let the receiver stall
   int stall_left = 0;

   // Empty the shadow queue and take on a new ring length; lengths beyond the
   // ring depth clamp to it. Ring contents are deliberately left alone, as in
   // the block: only entries written since can ever be read back.
   function automatic void apply_ring_length(logic [eqflm_pkg::COUNT_BITS-1:0] length_code);
      logic [eqflm_pkg::COUNT_BITS-1:0] len;
      len = (length_code > eqflm_pkg::RING_DEPTH_DEF)
            ? eqflm_pkg::COUNT_BITS'(eqflm_pkg::RING_DEPTH_DEF) : length_code;
      q_len        = len;
      q_front_full = 1'b0;
      q_front      = '0;
      q_head       = '0;
      q_tail       = '0;
      q_free       = len + eqflm_pkg::COUNT_BITS'(1);
      q_low_water  = len + eqflm_pkg::COUNT_BITS'(1);
   endfunction

   // Claim one entry and track the low-water mark of the free count.
   function automatic void take_entry();
      q_free = q_free - eqflm_pkg::COUNT_BITS'(1);
      if (q_low_water > q_free)
         q_low_water = q_free;
   endfunction

   // Move a ring index counter-clockwise, wrapping to the top of the ring.
   function automatic logic [eqflm_pkg::COUNT_BITS-1:0] ring_prev(
         logic [eqflm_pkg::COUNT_BITS-1:0] idx);
      if (idx == 0 || idx > q_len)
         idx = q_len;
      return idx - eqflm_pkg::COUNT_BITS'(1);
   endfunction

   // Apply one request to the shadow queue and return the response it earns.
   function automatic eqflm_pkg::rsp_type predict_queue_response(
         logic [eqflm_pkg::OP_BITS-1:0]     op,
         logic [eqflm_pkg::HANDLE_BITS-1:0] handle,
         logic                              use_margin,
         logic [eqflm_pkg::COUNT_BITS-1:0]  margin);
      eqflm_pkg::rsp_type               r;
      logic [eqflm_pkg::COUNT_BITS-1:0] slot;
      r.status    = eqflm_pkg::ST_DONE;
      r.event_out = '0;
      unique case (op)
         eqflm_pkg::OP_POST_FIFO: begin
            // With a margin, that many entries must stay free beyond this one.
            if (use_margin ? (q_free > margin) : (q_free != 0)) begin
               take_entry();
               if (!q_front_full) begin
                  q_front      = handle;
                  q_front_full = 1'b1;
               end else if (q_len != 0) begin
                  q_ring[q_head[RING_IW-1:0]] = handle;
                  q_head                      = ring_prev(q_head);
               end
            end else begin
               r.status = use_margin ? eqflm_pkg::ST_MARGIN : eqflm_pkg::ST_OVERFLOW;
            end
         end
         eqflm_pkg::OP_POST_LIFO: begin
            if (q_free == 0) begin
               r.status = eqflm_pkg::ST_OVERFLOW;
            end else begin
               take_entry();
               // Push the old front back into the ring just past the tail.
               if (q_front_full && q_len != 0) begin
                  slot = q_tail + eqflm_pkg::COUNT_BITS'(1);
                  if (slot >= q_len)
                     slot = '0;
                  q_tail                    = slot;
                  q_ring[slot[RING_IW-1:0]] = q_front;
               end
               q_front      = handle;
               q_front_full = 1'b1;
            end
         end
         eqflm_pkg::OP_GET: begin
            if (!q_front_full) begin
               r.status = eqflm_pkg::ST_EMPTY;
            end else begin
               r.event_out = q_front;
               q_free      = q_free + eqflm_pkg::COUNT_BITS'(1);
               // Refill the front from the tail while the ring still holds entries.
               if (q_free <= q_len) begin
                  q_front = q_ring[q_tail[RING_IW-1:0]];
                  q_tail  = ring_prev(q_tail);
               end else begin
                  q_front_full = 1'b0;
                  q_front      = '0;
               end
            end
         end
         default: ;  // unused opcode: counts only
      endcase
      r.free_now     = q_free;
      r.min_free_now = q_low_water;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Clock, and a hard stop should the block hang.
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // Receiver stalls: random stall bursts, begun only while stalling is allowed.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Beat monitor. Everything is sampled at the rising edge, before the
   // block's own updates land, so ordering within the step cannot matter.
   // Check the response first: it can only belong to an earlier request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_beats
      eqflm_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               $error("response beat with nothing outstanding");
               mismatches++;
            end else begin
               want = due_responses.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_event_out !== want.event_out) begin
                  $error("event_out: expected %0h, got %0h", want.event_out, rsp_event_out);
                  mismatches++;
               end
               if (rsp_free_now !== want.free_now) begin
                  $error("free_now: expected %0d, got %0d", want.free_now, rsp_free_now);
                  mismatches++;
               end
               if (rsp_min_free_now !== want.min_free_now) begin
                  $error("min_free_now: expected %0d, got %0d",
                         want.min_free_now, rsp_min_free_now);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready)
            apply_ring_length(csr_ring_length);
         if (req_valid && !req_stall)
            due_responses.push_back(predict_queue_response(req_operation, req_event_handle,
                                                           req_use_margin, req_margin));
      end
   end

   // ------------------------------------------------------------------
   // Drivers. All inputs change on the falling edge.
   // ------------------------------------------------------------------

   // Offer one request beat, maybe after a gap, and hold it until accepted.
   task automatic send_request(input logic [eqflm_pkg::OP_BITS-1:0]     op,
                               input logic [eqflm_pkg::HANDLE_BITS-1:0] handle,
                               input logic                              use_margin,
                               input logic [eqflm_pkg::COUNT_BITS-1:0]  margin);
      int gap;
      gap = (req_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_event_handle <= handle;
      req_use_margin   <= use_margin;
      req_margin       <= margin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop the request valid and wait for every outstanding response.
   task automatic settle_queue();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
   endtask

   // Write the ring length; only ever called with the block idle.
   task automatic write_ring_length(input logic [eqflm_pkg::COUNT_BITS-1:0] length_code);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_ring_length <= length_code;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Full-size ring straight out of reset: empty get, margin boundary,
   // handles at both extremes, a LIFO jump, the unused opcode, then drain.
   task automatic test_post_and_get();
      send_request(eqflm_pkg::OP_GET,       16'h5A5A, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_POST_FIFO, 16'hFFFF, 1'b1, 7'd65);   // free 65: refused
      send_request(eqflm_pkg::OP_POST_FIFO, 16'hFFFF, 1'b1, 7'd64);   // just fits
      send_request(eqflm_pkg::OP_POST_FIFO, 16'h0000, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_POST_LIFO, 16'hAAAA, 1'b0, 7'd33);
      send_request(OP_UNUSED,               16'h5555, 1'b1, 7'd42);
      repeat (4) send_request(eqflm_pkg::OP_GET, 16'h0000, 1'b0, 7'd0);
   endtask

   // Ring of no entries (capacity one) and of one entry: overflow on both
   // post kinds, a margin of nothing refused on a full queue, LIFO ordering.
   task automatic test_tiny_rings();
      settle_queue();
      write_ring_length(7'd0);
      send_request(eqflm_pkg::OP_POST_FIFO, 16'h1234, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_POST_FIFO, 16'hBEEF, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_POST_FIFO, 16'h0F0F, 1'b1, 7'd0);
      send_request(eqflm_pkg::OP_POST_LIFO, 16'hF0F0, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_GET,       16'h0000, 1'b0, 7'd0);
      settle_queue();
      write_ring_length(7'd1);
      send_request(eqflm_pkg::OP_POST_LIFO, 16'h1111, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_POST_LIFO, 16'h2222, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_POST_LIFO, 16'h3333, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_GET,       16'h0000, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_POST_FIFO, 16'h4444, 1'b1, 7'd1);
      repeat (2) send_request(eqflm_pkg::OP_GET, 16'h0000, 1'b0, 7'd0);
   endtask

   // An oversized length must clamp to the ring depth.
   task automatic test_length_saturation();
      settle_queue();
      write_ring_length(7'd127);
      send_request(eqflm_pkg::OP_GET,       16'h0000, 1'b0, 7'd0);
      send_request(eqflm_pkg::OP_POST_FIFO, 16'h8001, 1'b1, 7'd65);
   endtask

   // One setting of the ring length, then random traffic. The mix swings
   // between mostly posts and mostly gets so the queue runs full and empty
   // in turn; margins mostly fall within the capacity to hit the boundary.
   task automatic run_random_phase(input logic [eqflm_pkg::COUNT_BITS-1:0] length_code,
                                   input int items, input bit idle_allowed);
      int                            seg;
      int                            post_share;
      logic [eqflm_pkg::OP_BITS-1:0] op;
      settle_queue();
      write_ring_length(length_code);
      seg        = 0;
      post_share = 20;
      for (int i = 0; i < items; i++) begin
         if (seg == 0) begin
            seg        = $urandom_range(8, 2 * q_len + 12);
            post_share = (post_share > 50) ? $urandom_range(10, 35) : $urandom_range(65, 90);
            req_idling = idle_allowed && ($urandom_range(0, 3) != 0);
            rsp_idling = idle_allowed && ($urandom_range(0, 3) != 0);
         end
         seg--;
         if ($urandom_range(0, 99) < 2)
            op = OP_UNUSED;
         else if ($urandom_range(0, 99) < post_share)
            op = $urandom_range(0, 1) ? eqflm_pkg::OP_POST_LIFO : eqflm_pkg::OP_POST_FIFO;
         else
            op = eqflm_pkg::OP_GET;
         send_request(op, eqflm_pkg::HANDLE_BITS'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)),
                      eqflm_pkg::COUNT_BITS'(($urandom_range(0, 4) == 0)
                                             ? $urandom_range(0, 65)
                                             : $urandom_range(0, q_len + 1)));
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(7'd64, 250, 1'b1);
      run_random_phase(7'd0,  60,  1'b1);
      run_random_phase(7'd1,  60,  1'b1);
      run_random_phase(7'd2,  80,  1'b1);
      run_random_phase(7'd3,  80,  1'b1);
      repeat (4) run_random_phase(eqflm_pkg::COUNT_BITS'($urandom_range(4, 64)), 100, 1'b1);
   endtask

   // Closing stretch at full rate: no gaps, no stalls.
   task automatic test_unbroken_traffic();
      run_random_phase(7'd64, 200, 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Sequence: initialise every input, hold reset, run the
   // tests in turn, drain, then report.
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = eqflm_pkg::OP_GET;
      req_event_handle = '0;
      req_use_margin   = 1'b0;
      req_margin       = '0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_ring_length  = '0;
      apply_ring_length(eqflm_pkg::COUNT_BITS'(eqflm_pkg::RING_DEPTH_DEF));
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idling = 1'b1;
      rsp_idling = 1'b1;
      test_post_and_get();
      test_tiny_rings();
      test_length_saturation();
      test_random_traffic();
      test_unbroken_traffic();

      settle_queue();
      repeat (4) @(posedge clock);   // catch any stray beat after the last one
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
src/eqflm_pkg.sv
src/eqflm_ring_ram.sv
src/eqflm_queue.sv
src/event_queue_fifo_lifo_with_margin_core.sv
tb/sv/event_queue_fifo_lifo_with_margin_core_test.sv
